// ===== rtl/core/kct_pkg.sv =====
package kct_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ADDR_W    = 48;
  localparam int KEY_W     = 64;
  localparam int SIG_W     = 8;
  localparam int TIME_W    = 32;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_t;

  typedef struct packed {
    op_t                       operation;
    logic [ADDR_W-1:0]         station_address;
    logic [KEY_W-1:0]          key_high;
    logic [KEY_W-1:0]          key_low;
    logic signed [SIG_W-1:0]   signal_level;
    logic [TIME_W-1:0]         time_ms;
    logic [IDX_W-1:0]          entry_index;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic [KEY_W-1:0]          out_key_high;
    logic [KEY_W-1:0]          out_key_low;
    logic [ADDR_W-1:0]         out_address;
    logic signed [SIG_W-1:0]   out_signal;
    logic [TIME_W-1:0]         out_time;
    logic                      out_valid;
    logic [CNT_W-1:0]          entry_count;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0]         address;
    logic [KEY_W-1:0]          key_high;
    logic [KEY_W-1:0]          key_low;
    logic signed [SIG_W-1:0]   signal;
    logic [TIME_W-1:0]         stamp;
  } entry_t;

endpackage

// ===== rtl/core/kct_store.sv =====
module kct_store import kct_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/keyed_capture_table_oldest_replace.sv =====
// channel | signals           | handshake
// --------+-------------------+-----------------------------------------
// command | start, busy, req  | word taken when start && !busy
// result  | done, rsp         | word valid for the single cycle done is high
//
// Add with free room, clear, and a read past the count answer in the cycle after start.
// Read inside the count: one registered read of the entry store, then ST_READ answers.
// Lookup stops at a hit within count entries; a full-table add scans all. Both walk
// the store one entry a cycle through its single read port and one compare unit.
// Synchronous reset empties the table by clearing the count; no sweep of the store.
// busy is high in ST_READ and ST_SCAN; results cannot be stalled.
module keyed_capture_table_oldest_replace import kct_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t rsp
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  req_t              cur, cur_next;
  logic [CW-1:0]     limit, limit_next;
  logic [CW-1:0]     issue_ptr, issue_ptr_next;
  logic              chk_vld, chk_vld_next;
  logic [IW-1:0]     chk_idx, chk_idx_next;
  logic [IW-1:0]     best_idx, best_idx_next;
  logic [TIME_W-1:0] best_time, best_time_next;

  logic              emit;
  res_t              emit_res;
  res_t              hit_res;
  req_t              src;
  logic [CW-1:0]     count_inc;
  logic              scan_more;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  entry_t            rd_data;

  kct_store #(.DEPTH(TABLE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state != ST_IDLE);
  assign src       = (state == ST_IDLE) ? req : cur;
  assign count_inc = count + CW'(1);
  assign scan_more = (issue_ptr < limit);

  always_comb begin
    wr_data.address  = src.station_address;
    wr_data.key_high = src.key_high;
    wr_data.key_low  = src.key_low;
    wr_data.signal   = src.signal_level;
    wr_data.stamp    = src.time_ms;
  end

  always_comb begin
    hit_res.hit          = 1'b1;
    hit_res.out_key_high = rd_data.key_high;
    hit_res.out_key_low  = rd_data.key_low;
    hit_res.out_address  = rd_data.address;
    hit_res.out_signal   = rd_data.signal;
    hit_res.out_time     = rd_data.stamp;
    hit_res.out_valid    = 1'b1;
    hit_res.entry_count  = CNT_W'(count);
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    cur_next       = cur;
    limit_next     = limit;
    issue_ptr_next = issue_ptr;
    chk_vld_next   = 1'b0;
    chk_idx_next   = chk_idx;
    best_idx_next  = best_idx;
    best_time_next = best_time;
    wr_en          = 1'b0;
    wr_addr        = best_idx;
    rd_en          = 1'b0;
    rd_addr        = IW'(issue_ptr);
    emit           = 1'b0;
    emit_res       = '0;
    emit_res.entry_count = CNT_W'(count);

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (req.operation)
            OP_ADD: begin
              if (count < FULL) begin
                wr_en                = 1'b1;
                wr_addr              = IW'(count);
                count_next           = count_inc;
                emit                 = 1'b1;
                emit_res.entry_count = CNT_W'(count_inc);
              end else begin
                cur_next       = req;
                limit_next     = FULL;
                issue_ptr_next = '0;
                best_idx_next  = '0;
                best_time_next = '0;
                state_next     = ST_SCAN;
              end
            end
            OP_LOOKUP: begin
              if (count == '0) begin
                emit = 1'b1;
              end else begin
                cur_next       = req;
                limit_next     = count;
                issue_ptr_next = '0;
                state_next     = ST_SCAN;
              end
            end
            OP_READ: begin
              if (XW'(req.entry_index) < XW'(count)) begin
                rd_en      = 1'b1;
                rd_addr    = IW'(req.entry_index);
                state_next = ST_READ;
              end else begin
                emit = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_next           = '0;
              emit                 = 1'b1;
              emit_res.entry_count = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        emit       = 1'b1;
        emit_res   = hit_res;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (chk_vld && cur.operation == OP_LOOKUP &&
            rd_data.address == cur.station_address) begin
          emit       = 1'b1;
          emit_res   = hit_res;
          state_next = ST_IDLE;
        end else if (!chk_vld && !scan_more) begin
          // walk finished: lookup missed, or add replaces the oldest entry
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (cur.operation == OP_ADD) begin
            wr_en   = 1'b1;
            wr_addr = best_idx;
          end
        end else begin
          rd_en        = scan_more;
          chk_vld_next = scan_more;
          chk_idx_next = IW'(issue_ptr);
          if (scan_more) begin
            issue_ptr_next = issue_ptr + CW'(1);
          end
          if (chk_vld && cur.operation == OP_ADD &&
              (chk_idx == '0 || rd_data.stamp < best_time)) begin
            best_idx_next  = chk_idx;
            best_time_next = rd_data.stamp;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      chk_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      chk_vld <= chk_vld_next;
      done    <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    limit     <= limit_next;
    issue_ptr <= issue_ptr_next;
    chk_idx   <= chk_idx_next;
    best_idx  <= best_idx_next;
    best_time <= best_time_next;
    if (emit) begin
      rsp <= emit_res;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("fill count above table depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither running nor answered");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.hit) |-> (rsp.out_valid == 1'b0 && rsp.out_time == '0 &&
                            rsp.out_address == '0))
    else $error("miss result carries entry data");

  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_ptr <= limit))
    else $error("scan pointer past its limit");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import kct_pkg::*;

  localparam int RAND_WORDS = 1082;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = DEPTH_DEF + 4;
  localparam int POOL_SIZE = 6;

  typedef struct {
    req_t word;
    bit fixed;
    logic [CNT_W-1:0] count;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  res_t rsp;

  entry_t slots [DEPTH_DEF];
  logic slot_mark [DEPTH_DEF];
  int fill;
  res_t pending [$];
  step_row_t script [$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  int errors = 0;
  int stall_cycles = 0;

  keyed_capture_table_oldest_replace #(.TABLE_DEPTH(DEPTH_DEF)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic res_t slot_result(int s);
    res_t r;
    r = '0;
    r.hit = 1'b1;
    r.out_key_high = slots[s].key_high;
    r.out_key_low = slots[s].key_low;
    r.out_address = slots[s].address;
    r.out_signal = slots[s].signal;
    r.out_time = slots[s].stamp;
    r.out_valid = slot_mark[s];
    return r;
  endfunction

  function automatic res_t apply_capture_op(req_t w);
    res_t r;
    int victim;
    r = '0;
    case (w.operation)
      OP_ADD: begin
        if (fill < DEPTH_DEF) begin
          victim = fill;
        end else begin
          victim = 0;
          for (int i = 1; i < DEPTH_DEF; i++)
            if (slots[i].stamp < slots[victim].stamp) victim = i;
        end
        slots[victim].address = w.station_address;
        slots[victim].key_high = w.key_high;
        slots[victim].key_low = w.key_low;
        slots[victim].signal = w.signal_level;
        slots[victim].stamp = w.time_ms;
        slot_mark[victim] = 1'b1;
        if (fill < DEPTH_DEF) fill++;
      end
      OP_LOOKUP: begin
        for (int i = 0; i < fill; i++) begin
          if (slots[i].address == w.station_address) begin
            r = slot_result(i);
            break;
          end
        end
      end
      OP_READ: begin
        if (int'(w.entry_index) < fill) r = slot_result(int'(w.entry_index));
      end
      default: begin
        for (int i = 0; i < DEPTH_DEF; i++) begin
          slots[i] = '0;
          slot_mark[i] = 1'b0;
        end
        fill = 0;
      end
    endcase
    r.entry_count = CNT_W'(fill);
    return r;
  endfunction

  function automatic step_row_t row(op_t op, logic [ADDR_W-1:0] a, logic [KEY_W-1:0] kh,
                                    logic [KEY_W-1:0] kl, logic [SIG_W-1:0] s,
                                    logic [TIME_W-1:0] t, logic [IDX_W-1:0] idx,
                                    bit fixed, logic [CNT_W-1:0] cnt);
    step_row_t r;
    r.word.operation = op;
    r.word.station_address = a;
    r.word.key_high = kh;
    r.word.key_low = kl;
    r.word.signal_level = s;
    r.word.time_ms = t;
    r.word.entry_index = idx;
    r.fixed = fixed;
    r.count = cnt;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] random_stamp();
    case ($urandom_range(2))
      0: return TIME_W'($urandom_range(7));
      1: return $urandom;
      default: return 32'hFFFF_FFF8 + TIME_W'($urandom_range(7));
    endcase
  endfunction

  function automatic req_t random_word();
    req_t w;
    int pick;
    w.station_address = ADDR_W'({$urandom, $urandom});
    w.key_high = {$urandom, $urandom};
    w.key_low = {$urandom, $urandom};
    w.signal_level = SIG_W'($urandom);
    w.time_ms = random_stamp();
    w.entry_index = IDX_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 43) w.operation = OP_ADD;
    else if (pick < 70) w.operation = OP_LOOKUP;
    else if (pick < 98) w.operation = OP_READ;
    else w.operation = OP_CLEAR;
    if (w.operation inside {OP_ADD, OP_LOOKUP} && $urandom_range(99) < 70)
      w.station_address = addr_pool[$urandom_range(POOL_SIZE - 1)];
    if (w.operation == OP_READ && fill > 0 && $urandom_range(99) < 60)
      w.entry_index = IDX_W'($urandom_range(fill - 1));
    return w;
  endfunction

  task automatic issue(input req_t w, input bit fixed, input logic [CNT_W-1:0] cnt);
    res_t want;
    start <= 1'b1;
    req <= w;
    do @(posedge clk); while (busy !== 1'b0);
    want = apply_capture_op(w);
    if (fixed) begin
      want = '0;
      want.entry_count = cnt;
    end
    pending.push_back(want);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  function automatic void match_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && done === 1'b1) begin
      if (pending.size() == 0) begin
        $error("unexpected result word: %0h", rsp);
        errors++;
      end else begin
        want = pending.pop_front();
        match_field("hit", KEY_W'(want.hit), KEY_W'(rsp.hit));
        match_field("out_key_high", want.out_key_high, rsp.out_key_high);
        match_field("out_key_low", want.out_key_low, rsp.out_key_low);
        match_field("out_address", KEY_W'(want.out_address), KEY_W'(rsp.out_address));
        match_field("out_signal", {56'd0, want.out_signal}, {56'd0, rsp.out_signal});
        match_field("out_time", KEY_W'(want.out_time), KEY_W'(rsp.out_time));
        match_field("out_valid", KEY_W'(want.out_valid), KEY_W'(rsp.out_valid));
        match_field("entry_count", KEY_W'(want.entry_count), KEY_W'(rsp.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] ones_a;
    logic [ADDR_W-1:0] dup_a;
    logic [KEY_W-1:0] ones_k;
    ones_a = '1;
    ones_k = '1;
    dup_a = 48'h0A0B_0C0D_0E0F;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    fill = 0;
    for (int i = 0; i < DEPTH_DEF; i++) begin
      slots[i] = '0;
      slot_mark[i] = 1'b0;
    end
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'({$urandom, $urandom});
    addr_pool[0] = ones_a;
    addr_pool[1] = '0;

    script.push_back(row(OP_READ,   '0, '0, '0, '0, '0, 4'd0, 1'b1, 5'd0));
    script.push_back(row(OP_LOOKUP, '0, '0, '0, '0, '0, '0, 1'b1, 5'd0));
    script.push_back(row(OP_READ,   '0, '0, '0, '0, '0, 4'd15, 1'b1, 5'd0));
    script.push_back(row(OP_ADD,    '0, '0, '0, '0, '0, '0, 1'b1, 5'd1));
    script.push_back(row(OP_ADD,    ones_a, ones_k, ones_k, '1, '1, '1, 1'b1, 5'd2));
    script.push_back(row(OP_LOOKUP, ones_a, '0, '0, '0, '0, '0, 1'b0, '0));
    script.push_back(row(OP_READ,   '0, '0, '0, '0, '0, 4'd0, 1'b0, '0));
    script.push_back(row(OP_READ,   '0, '0, '0, '0, '0, 4'd1, 1'b0, '0));
    script.push_back(row(OP_READ,   ones_a, '0, '0, '0, '0, 4'd2, 1'b1, 5'd2));
    script.push_back(row(OP_ADD,    dup_a, 64'h1, 64'h2, 8'h80, 32'd5, '0, 1'b1, 5'd3));
    script.push_back(row(OP_ADD,    dup_a, 64'h3, 64'h4, 8'h7F, 32'd5, '0, 1'b1, 5'd4));
    script.push_back(row(OP_LOOKUP, dup_a, '0, '0, '0, '0, '0, 1'b0, '0));
    script.push_back(row(OP_LOOKUP, '0, ones_k, ones_k, '1, '1, '1, 1'b0, '0));
    script.push_back(row(OP_LOOKUP, 48'h1, '0, '0, '0, '0, '0, 1'b1, 5'd4));
    script.push_back(row(OP_READ,   '0, '0, '0, '0, '0, 4'd3, 1'b0, '0));
    script.push_back(row(OP_CLEAR,  '0, '0, '0, '0, '0, '0, 1'b1, 5'd0));
    script.push_back(row(OP_READ,   '0, '0, '0, '0, '0, 4'd0, 1'b1, 5'd0));
    script.push_back(row(OP_LOOKUP, ones_a, '0, '0, '0, '0, '0, 1'b1, 5'd0));
    script.push_back(row(OP_CLEAR,  ones_a, ones_k, ones_k, '1, '1, '1, 1'b1, 5'd0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if ($urandom_range(99) < 18) begin
        start <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < 18);
      end
      issue(script[i].word, script[i].fixed, script[i].count);
    end
    drain();

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == 700) begin
        drain();
      end else if (!(n >= 300 && n < 500) && $urandom_range(99) < 18) begin
        start <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < 18);
      end
      issue(random_word(), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/kct_pkg.sv
rtl/core/kct_store.sv
rtl/core/keyed_capture_table_oldest_replace.sv
tb/sv/tb_top.sv
